### rtl/wfm_pkg.sv
// Shared types and constants of the wildcard file name matcher.
`default_nettype none
package wfm_pkg;

  localparam int CHAR_W    = 8;
  localparam int POS_W     = 5;
  localparam int MAX_CHARS = 16;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;
  localparam int LEN_W     = 5;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    REG_TMPL_LO = 2'd0,
    REG_TMPL_HI = 2'd1,
    REG_TMPL_LEN = 2'd2,
    REG_FOLD_CASE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_BASE = 2'd0,
    PH_STAR = 2'd1,
    PH_EXT  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SKIP,
    ST_FIN_BASE,
    ST_FIN_SKIP,
    ST_FIN_DOT,
    ST_FIN_EXT
  } state_t;

  typedef struct packed {
    logic   load_char;
    logic   pos_inc;
    logic   phase_we;
    phase_t phase_val;
    logic   verdict_we;
    logic   verdict_val;
    logic   result_we;
    logic   result_val;
    logic   clear_match;
  } cmd_t;

  typedef struct packed {
    logic   c_zero;
    logic   c_dot;
    logic   c_eq_t;
    logic   t_end;
    logic   t_dot;
    logic   t_qmark;
    logic   t_star;
    phase_t phase;
    logic   verdict;
  } sts_t;

endpackage
`default_nettype wire

### rtl/wfm_regs.sv
// Configuration register file of the matcher behind an APB-style port.
`default_nettype none
module wfm_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wfm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [wfm_pkg::DATA_W-1:0]   pwdata,
  output logic      [wfm_pkg::DATA_W-1:0]   prdata,
  output logic      [wfm_pkg::DATA_W-1:0]   tmpl_lo,
  output logic      [wfm_pkg::DATA_W-1:0]   tmpl_hi,
  output logic      [wfm_pkg::LEN_W-1:0]    tmpl_len,
  output logic                              fold_case
);

  wfm_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = wfm_pkg::reg_idx_t'(paddr[wfm_pkg::ADDR_W-1:3]);
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tmpl_lo   <= '0;
      tmpl_hi   <= '0;
      tmpl_len  <= '0;
      fold_case <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        wfm_pkg::REG_TMPL_LO:   tmpl_lo   <= pwdata;
        wfm_pkg::REG_TMPL_HI:   tmpl_hi   <= pwdata;
        wfm_pkg::REG_TMPL_LEN:  tmpl_len  <= pwdata[wfm_pkg::LEN_W-1:0];
        wfm_pkg::REG_FOLD_CASE: fold_case <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      wfm_pkg::REG_TMPL_LO:   prdata = tmpl_lo;
      wfm_pkg::REG_TMPL_HI:   prdata = tmpl_hi;
      wfm_pkg::REG_TMPL_LEN:  prdata[wfm_pkg::LEN_W-1:0] = tmpl_len;
      wfm_pkg::REG_FOLD_CASE: prdata[0] = fold_case;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/wfm_dp.sv
// Matcher datapath: character latch, template position, phase, verdict and result.
`default_nettype none
module wfm_dp #(
  parameter int TEMPLATE_CHARS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [wfm_pkg::DATA_W-1:0]   tmpl_lo,
  input  wire logic [wfm_pkg::DATA_W-1:0]   tmpl_hi,
  input  wire logic [wfm_pkg::LEN_W-1:0]    tmpl_len,
  input  wire logic                         fold_case,
  input  wire logic [wfm_pkg::CHAR_W-1:0]   name_char,
  input  wire wfm_pkg::cmd_t                cmd,
  output wfm_pkg::sts_t                     sts,
  output logic                              matched
);

  localparam logic [wfm_pkg::LEN_W-1:0] LEN_MAX = wfm_pkg::LEN_W'(TEMPLATE_CHARS);

  function automatic logic [wfm_pkg::CHAR_W-1:0] fold_char(
    input logic [wfm_pkg::CHAR_W-1:0] c,
    input logic                       en
  );
    logic is_lower;
    is_lower = (c >= wfm_pkg::CH_LO_A) && (c <= wfm_pkg::CH_LO_Z);
    return (en && is_lower) ? c - wfm_pkg::CASE_OFS : c;
  endfunction

  logic [wfm_pkg::MAX_CHARS-1:0][wfm_pkg::CHAR_W-1:0] tmpl_bytes;
  logic [wfm_pkg::LEN_W-1:0]    len_eff;
  logic [wfm_pkg::CHAR_W-1:0]   t_char;
  logic [wfm_pkg::CHAR_W-1:0]   c_char;
  logic [wfm_pkg::POS_W-1:0]    pos;
  wfm_pkg::phase_t              phase;
  logic                         verdict;

  assign tmpl_bytes = {tmpl_hi, tmpl_lo};
  assign len_eff    = (tmpl_len > LEN_MAX) ? LEN_MAX : tmpl_len;

  always_comb begin
    if (wfm_pkg::LEN_W'(pos) >= len_eff) begin
      t_char = wfm_pkg::CH_NUL;
    end else begin
      t_char = fold_char(tmpl_bytes[pos[3:0]], fold_case);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      c_char <= fold_char(name_char, fold_case);
    end
    if (cmd.result_we) begin
      matched <= cmd.result_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_match) begin
      pos     <= '0;
      phase   <= wfm_pkg::PH_BASE;
      verdict <= 1'b1;
    end else begin
      if (cmd.pos_inc) begin
        pos <= pos + 1'b1;
      end
      if (cmd.phase_we) begin
        phase <= cmd.phase_val;
      end
      if (cmd.verdict_we) begin
        verdict <= cmd.verdict_val;
      end
    end
  end

  always_comb begin
    sts.c_zero  = (c_char == wfm_pkg::CH_NUL);
    sts.c_dot   = (c_char == wfm_pkg::CH_DOT);
    sts.c_eq_t  = (c_char == t_char);
    sts.t_end   = (t_char == wfm_pkg::CH_NUL);
    sts.t_dot   = (t_char == wfm_pkg::CH_DOT);
    sts.t_qmark = (t_char == wfm_pkg::CH_QMARK);
    sts.t_star  = (t_char == wfm_pkg::CH_STAR);
    sts.phase   = phase;
    sts.verdict = verdict;
  end

endmodule
`default_nettype wire

### rtl/wfm_ctrl.sv
// Matcher controller: sequences character steps, template scans and result hand-off.
`default_nettype none
module wfm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire wfm_pkg::sts_t  sts,
  output wfm_pkg::cmd_t       cmd
);

  wfm_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            out_free;
  logic            done_now;
  logic            done_val;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == wfm_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wfm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_now   = 1'b0;
    done_val   = 1'b0;
    unique case (state)
      wfm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_char = 1'b1;
          state_next    = wfm_pkg::ST_STEP;
        end
      end
      wfm_pkg::ST_STEP: begin
        if (sts.c_zero) begin
          unique case (sts.phase)
            wfm_pkg::PH_BASE: state_next = wfm_pkg::ST_FIN_BASE;
            wfm_pkg::PH_STAR: state_next = wfm_pkg::ST_FIN_DOT;
            wfm_pkg::PH_EXT:  state_next = wfm_pkg::ST_FIN_EXT;
            wfm_pkg::PH_DONE: begin
              done_now = 1'b1;
              done_val = sts.verdict;
            end
            default: ;
          endcase
        end else begin
          state_next = wfm_pkg::ST_IDLE;
          unique case (sts.phase)
            wfm_pkg::PH_BASE: begin
              priority if (sts.c_dot && (sts.t_end || sts.t_dot)) begin
                cmd.pos_inc   = sts.t_dot;
                cmd.phase_we  = 1'b1;
                cmd.phase_val = wfm_pkg::PH_EXT;
              end else if (sts.c_eq_t || sts.t_qmark) begin
                cmd.pos_inc = 1'b1;
              end else if (sts.t_star) begin
                state_next = wfm_pkg::ST_SKIP;
              end else begin
                cmd.verdict_we  = 1'b1;
                cmd.verdict_val = 1'b0;
                cmd.phase_we    = 1'b1;
                cmd.phase_val   = wfm_pkg::PH_DONE;
              end
            end
            wfm_pkg::PH_STAR: begin
              if (sts.c_dot) begin
                cmd.pos_inc   = sts.t_dot;
                cmd.phase_we  = 1'b1;
                cmd.phase_val = wfm_pkg::PH_EXT;
              end
            end
            wfm_pkg::PH_EXT: begin
              if (sts.c_eq_t || sts.t_qmark) begin
                cmd.pos_inc = 1'b1;
              end else begin
                cmd.verdict_we  = 1'b1;
                cmd.verdict_val = sts.t_star;
                cmd.phase_we    = 1'b1;
                cmd.phase_val   = wfm_pkg::PH_DONE;
              end
            end
            wfm_pkg::PH_DONE: ;
            default: ;
          endcase
        end
      end
      wfm_pkg::ST_SKIP: begin
        if (!sts.t_end && !sts.t_dot) begin
          cmd.pos_inc = 1'b1;
        end else begin
          cmd.phase_we = 1'b1;
          if (sts.c_dot) begin
            cmd.pos_inc   = sts.t_dot;
            cmd.phase_val = wfm_pkg::PH_EXT;
          end else begin
            cmd.phase_val = wfm_pkg::PH_STAR;
          end
          state_next = wfm_pkg::ST_IDLE;
        end
      end
      wfm_pkg::ST_FIN_BASE: begin
        priority if (sts.t_end || sts.t_dot) begin
          state_next = wfm_pkg::ST_FIN_DOT;
        end else if (sts.t_qmark) begin
          cmd.pos_inc = 1'b1;
        end else if (sts.t_star) begin
          state_next = wfm_pkg::ST_FIN_SKIP;
        end else begin
          done_now = 1'b1;
          done_val = 1'b0;
        end
      end
      wfm_pkg::ST_FIN_SKIP: begin
        if (!sts.t_end && !sts.t_dot) begin
          cmd.pos_inc = 1'b1;
        end else begin
          state_next = wfm_pkg::ST_FIN_DOT;
        end
      end
      wfm_pkg::ST_FIN_DOT: begin
        cmd.pos_inc = sts.t_dot;
        state_next  = wfm_pkg::ST_FIN_EXT;
      end
      wfm_pkg::ST_FIN_EXT: begin
        priority if (sts.t_end) begin
          done_now = 1'b1;
          done_val = 1'b1;
        end else if (sts.t_qmark) begin
          cmd.pos_inc = 1'b1;
        end else begin
          done_now = 1'b1;
          done_val = sts.t_star;
        end
      end
      default: state_next = wfm_pkg::ST_IDLE;
    endcase

    if (done_now && out_free) begin
      cmd.result_we   = 1'b1;
      cmd.result_val  = done_val;
      cmd.clear_match = 1'b1;
      state_next      = wfm_pkg::ST_IDLE;
    end

    out_valid_next = (out_valid && !out_ready) || cmd.result_we;
  end

endmodule
`default_nettype wire

### rtl/wildcard_filename_matcher_core.sv
// Top level of the 8.3-style wildcard file name matcher.
// A file name streams in one character per transaction on in_valid/in_ready and ends
// with a zero character, which yields one transaction on out_valid/out_ready carrying
// matched. A nonzero character is accepted, then takes one step; a '*' met in the base
// part then skips template positions until it reaches a dot or the end of the template.
// The terminator yields the result from the step state when the name is already decided.
// Otherwise it scans the rest of the template until decided: in the extension directly,
// after a base '*' past the dot first, and in the base part through the base (skipping
// a '*' still in the base template), past the dot and then through the extension.
// The controller steps the single template read port one position per cycle. A finished
// result sits in an output register, so characters of the next name are taken while it
// waits; the next terminator holds until it is taken. The template is configured over
// the APB-style port at byte addresses 0, 8, 16 and 24; the user must do so only while
// no name is in flight, which the block itself does not enforce.
`default_nettype none
module wildcard_filename_matcher_core #(
  parameter int TEMPLATE_CHARS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wfm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [wfm_pkg::DATA_W-1:0]   pwdata,
  output logic      [wfm_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [wfm_pkg::CHAR_W-1:0]   name_char,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              matched
);

  logic [wfm_pkg::DATA_W-1:0] tmpl_lo;
  logic [wfm_pkg::DATA_W-1:0] tmpl_hi;
  logic [wfm_pkg::LEN_W-1:0]  tmpl_len;
  logic                       fold_case;
  wfm_pkg::cmd_t              cmd;
  wfm_pkg::sts_t              sts;

  assign pready = 1'b1;

  wfm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .tmpl_lo   (tmpl_lo),
    .tmpl_hi   (tmpl_hi),
    .tmpl_len  (tmpl_len),
    .fold_case (fold_case)
  );

  wfm_dp #(
    .TEMPLATE_CHARS (TEMPLATE_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .tmpl_lo   (tmpl_lo),
    .tmpl_hi   (tmpl_hi),
    .tmpl_len  (tmpl_len),
    .fold_case (fold_case),
    .name_char (name_char),
    .cmd       (cmd),
    .sts       (sts),
    .matched   (matched)
  );

  wfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  a_char_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared right after a character transaction");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (sts.phase == wfm_pkg::PH_BASE) && sts.verdict)
    else $error("match state not cleared when a result was issued");

  a_two_cycle_min: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("character accepted before the previous one was processed");

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the wildcard file name matcher: directed and random templates and streamed names.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wfm_pkg::*;

  localparam logic [CHAR_W-1:0] UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] UP_Z = 8'h5A;
  localparam int NAME_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int PRESSURE_PHASE = 5;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = MAX_CHARS + 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CHAR_W-1:0]   name_char = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                matched;

  // configuration mirror
  logic [DATA_W-1:0]   cfg_lo = '0;
  logic [DATA_W-1:0]   cfg_hi = '0;
  logic [LEN_W-1:0]    cfg_len = '0;
  logic                cfg_fold = 1'b1;

  // matcher state mirror
  int                  tmpl_pos = 0;
  phase_t              scan_phase = PH_BASE;
  bit                  still_matching = 1'b1;

  logic [CHAR_W-1:0]   name_chars_pending[$];
  bit                  verdicts_due[$];
  int                  errors = 0;
  bit                  in_acc = 1'b0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  bit                  long_hold = 1'b0;

  wildcard_filename_matcher_core #(.TEMPLATE_CHARS(MAX_CHARS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .name_char(name_char),
    .out_valid(out_valid), .out_ready(out_ready), .matched(matched)
  );

  always #5 clk = ~clk;

  function automatic logic [CHAR_W-1:0] fold_ch(input logic [CHAR_W-1:0] c);
    if (cfg_fold && c >= CH_LO_A && c <= CH_LO_Z) return c - CASE_OFS;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] tmpl_at(input int p);
    int lim;
    logic [CHAR_W-1:0] b;
    lim = (cfg_len > MAX_CHARS) ? MAX_CHARS : int'(cfg_len);
    if (p >= lim) return CH_NUL;
    b = (p < 8) ? cfg_lo[8*p +: 8] : cfg_hi[8*(p-8) +: 8];
    return fold_ch(b);
  endfunction

  function automatic void skip_to_dot();
    logic [CHAR_W-1:0] t;
    t = tmpl_at(tmpl_pos);
    while (t != CH_NUL && t != CH_DOT) begin
      tmpl_pos++;
      t = tmpl_at(tmpl_pos);
    end
  endfunction

  function automatic bit ext_rest_ok();
    logic [CHAR_W-1:0] t;
    t = tmpl_at(tmpl_pos);
    while (t != CH_NUL) begin
      if (t != CH_QMARK) return (t == CH_STAR);
      tmpl_pos++;
      t = tmpl_at(tmpl_pos);
    end
    return 1'b1;
  endfunction

  function automatic bit name_end_verdict();
    logic [CHAR_W-1:0] t;
    case (scan_phase)
      PH_BASE: begin
        t = tmpl_at(tmpl_pos);
        while (t != CH_NUL && t != CH_DOT) begin
          if (t == CH_QMARK) begin
            tmpl_pos++;
          end else if (t == CH_STAR) begin
            skip_to_dot();
            break;
          end else begin
            return 1'b0;
          end
          t = tmpl_at(tmpl_pos);
        end
        if (tmpl_at(tmpl_pos) == CH_DOT) tmpl_pos++;
        return ext_rest_ok();
      end
      PH_STAR: begin
        if (tmpl_at(tmpl_pos) == CH_DOT) tmpl_pos++;
        return ext_rest_ok();
      end
      PH_EXT: return ext_rest_ok();
      default: return still_matching;
    endcase
  endfunction

  // returns 1 when the character closes a name; verdict_out then holds its verdict
  function automatic bit match_char(input logic [CHAR_W-1:0] raw, output bit verdict_out);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] t;
    c = fold_ch(raw);
    t = tmpl_at(tmpl_pos);
    verdict_out = 1'b0;
    if (c == CH_NUL) begin
      verdict_out = name_end_verdict();
      tmpl_pos = 0;
      scan_phase = PH_BASE;
      still_matching = 1'b1;
      return 1'b1;
    end
    case (scan_phase)
      PH_BASE: begin
        if (c == CH_DOT && (t == CH_NUL || t == CH_DOT)) begin
          if (t == CH_DOT) tmpl_pos++;
          scan_phase = PH_EXT;
        end else if (c == t || t == CH_QMARK) begin
          tmpl_pos++;
        end else if (t == CH_STAR) begin
          skip_to_dot();
          if (c == CH_DOT) begin
            if (tmpl_at(tmpl_pos) == CH_DOT) tmpl_pos++;
            scan_phase = PH_EXT;
          end else begin
            scan_phase = PH_STAR;
          end
        end else begin
          still_matching = 1'b0;
          scan_phase = PH_DONE;
        end
      end
      PH_STAR: begin
        if (c == CH_DOT) begin
          if (t == CH_DOT) tmpl_pos++;
          scan_phase = PH_EXT;
        end
      end
      PH_EXT: begin
        if (c == t || t == CH_QMARK) begin
          tmpl_pos++;
        end else begin
          still_matching = (t == CH_STAR);
          scan_phase = PH_DONE;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_letter();
    logic [CHAR_W-1:0] c;
    c = UP_A + CHAR_W'($urandom_range(5));
    if ($urandom_range(1) != 0) c = c | CASE_OFS;
    return c;
  endfunction

  function automatic bit is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= UP_A && c <= UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_sym();
    int r;
    r = $urandom_range(9);
    if (r < 6) return rand_letter();
    if (r == 6) return CH_DOT;
    if (r == 7) return CH_QMARK;
    if (r == 8) return CH_STAR;
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [DATA_W-1:0] rand_tmpl_word();
    logic [DATA_W-1:0] w;
    int r;
    for (int k = 0; k < 8; k++) begin
      r = $urandom_range(99);
      if (r < 45) w[8*k +: 8] = rand_letter();
      else if (r < 58) w[8*k +: 8] = CH_QMARK;
      else if (r < 68) w[8*k +: 8] = CH_STAR;
      else if (r < 80) w[8*k +: 8] = CH_DOT;
      else if (r < 97) w[8*k +: 8] = CHAR_W'($urandom_range(1, 255));
      else w[8*k +: 8] = CH_NUL;
    end
    return w;
  endfunction

  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TMPL_LO: cfg_lo = val;
      REG_TMPL_HI: cfg_hi = val;
      REG_TMPL_LEN: cfg_len = val[LEN_W-1:0];
      default: cfg_fold = val[0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_template(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                               input int len, input bit fold);
    logic [DATA_W-1:0] v;
    reg_write(REG_TMPL_LO, lo);
    reg_write(REG_TMPL_HI, hi);
    v = {$urandom, $urandom};
    v[LEN_W-1:0] = LEN_W'(len);
    reg_write(REG_TMPL_LEN, v);
    v = {$urandom, $urandom};
    v[0] = fold;
    reg_write(REG_FOLD_CASE, v);
  endtask

  task automatic queue_name(output int count);
    logic [CHAR_W-1:0] nm[$];
    logic [CHAR_W-1:0] t;
    logic [CHAR_W-1:0] c;
    int r;
    int p;
    int n;
    bit in_ext;
    r = $urandom_range(99);
    if (r < 70) begin
      // follow the template with random content
      p = 0;
      in_ext = 1'b0;
      t = tmpl_at(p);
      while (t != CH_NUL && $urandom_range(99) >= 4) begin
        if (t == CH_QMARK) begin
          if ($urandom_range(9) != 0) nm.push_back(rand_letter());
        end else if (t == CH_STAR) begin
          n = $urandom_range(3);
          repeat (n) nm.push_back(in_ext ? CHAR_W'($urandom_range(1, 255)) : rand_letter());
        end else begin
          if (t == CH_DOT) in_ext = 1'b1;
          c = t;
          if (is_alpha(c) && $urandom_range(3) == 0) c = c ^ CASE_OFS;
          nm.push_back(c);
        end
        p++;
        t = tmpl_at(p);
      end
      if (nm.size() > 0 && $urandom_range(6) == 0)
        nm[$urandom_range(nm.size() - 1)] = CHAR_W'($urandom_range(1, 255));
    end else if (r < 87) begin
      n = $urandom_range(10);
      repeat (n) nm.push_back(rand_sym());
    end else begin
      n = $urandom_range(8);
      repeat (n) nm.push_back(CHAR_W'($urandom_range(1, 255)));
    end
    foreach (nm[i]) name_chars_pending.push_back(nm[i]);
    name_chars_pending.push_back(CH_NUL);
    count = nm.size() + 1;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) name_chars_pending.push_back(s[i]);
    name_chars_pending.push_back(CH_NUL);
  endtask

  task automatic wait_drained();
    while (name_chars_pending.size() != 0 || in_valid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // name character driver
  always @(negedge clk) begin
    if (!in_valid || in_acc) begin
      if (!rst && name_chars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        name_char <= name_chars_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // verdict receiver
  always @(negedge clk) begin
    if (long_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor and scoreboard
  always @(posedge clk) begin : monitor
    bit got;
    bit want;
    in_acc = in_valid && in_ready && !rst;
    if (in_acc) begin
      if (match_char(name_char, got)) verdicts_due.push_back(got);
    end
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected transaction: matched actual %0d, none expected", matched);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (matched !== want) begin
          $error("matched: expected %0d, actual %0d", want, matched);
          errors++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int len;
    bit fold;
    int n;
    int cnt;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: template A?C*.?B* with case folding
    load_template(64'h2A423F2E2A433F41, 64'h0, 8, 1'b1);
    push_str("abcd.xbz");
    push_str("A.");
    push_str("AB");
    push_str("AbCzz.q");
    name_chars_pending.push_back(8'hFF);
    name_chars_pending.push_back(8'h01);
    name_chars_pending.push_back(CH_STAR);
    name_chars_pending.push_back(CH_QMARK);
    name_chars_pending.push_back(CH_NUL);
    name_chars_pending.push_back(CH_NUL);
    wait_drained();

    for (int ph = 0; ph < NAME_PHASES; ph++) begin
      lo = rand_tmpl_word();
      hi = rand_tmpl_word();
      fold = $urandom_range(1);
      len = $urandom_range(MAX_CHARS);
      case (ph)
        0: begin len = MAX_CHARS; fold = 1'b0; end
        1: begin len = 0; fold = 1'b1; end
        2: begin len = 31; fold = 1'b1; end
        3: begin len = $urandom_range(MAX_CHARS + 1, 31); fold = 1'b0; end
        4: begin lo = '1; hi = '1; len = MAX_CHARS; end
        8: begin lo[8*$urandom_range(7) +: 8] = CH_NUL; len = MAX_CHARS; end
        default: ;
      endcase
      load_template(lo, hi, len, fold);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 81; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 81; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      if (ph == PRESSURE_PHASE) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        queue_name(cnt);
        n += cnt;
      end
      if (ph == PRESSURE_PHASE) begin
        @(posedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
